// File: sv/assert_macros.svh
// Assertion helpers used by the checker file jcs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_SYNC(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rstn, cond, cons, msg) \
    `ASSERT_SYNC(label, clk, rstn, (cond) |-> (cons), msg)

`endif

// File: sv/jcs_pkg.sv
// ----------------------------------------------------------------------------
// jcs_pkg
// Types and character codes shared by the comment stripper modules.
// ----------------------------------------------------------------------------
package jcs_pkg;

    localparam int UNIT_BITS = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [UNIT_BITS-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [UNIT_BITS-1:0] CH_QUOTE     = 16'h0022;
    localparam logic [UNIT_BITS-1:0] CH_SLASH     = 16'h002F;
    localparam logic [UNIT_BITS-1:0] CH_STAR      = 16'h002A;
    localparam logic [UNIT_BITS-1:0] CH_NEWLINE   = 16'h000A;

    typedef enum logic [6:0] {
        MODE_NORMAL     = 7'b0000001,
        MODE_HELD       = 7'b0000010,
        MODE_STR        = 7'b0000100,
        MODE_STR_ESC    = 7'b0001000,
        MODE_LINE       = 7'b0010000,
        MODE_BLOCK      = 7'b0100000,
        MODE_BLOCK_STAR = 7'b1000000
    } scan_mode_t;

    typedef struct packed {
        logic                 emit_slash;
        logic                 emit_unit;
        logic [UNIT_BITS-1:0] unit;
        logic                 text_fin;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } queue_head_t;

endpackage

// File: sv/json_comment_stripper.sv
// The stripper takes one code unit per cycle and passes text on with line and
// block comments removed; a unit is taken in every cycle while the four-entry
// job queue has room. Most units give one result transfer; a held slash
// followed by a unit that does not open a comment gives two, and those two
// leave the output register one after the other, so with m_tready high the
// output side sets the sustained rate at one result per cycle. A dropped
// unit that is not the last of the text gives no transfer; the last unit
// always gives one marked as the end of the text.
// ----------------------------------------------------------------------------
// json_comment_stripper
// Streaming comment remover for JSON text with comments.
// ----------------------------------------------------------------------------
module json_comment_stripper
    import jcs_pkg::*;
#(
    parameter int UNIT_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [UNIT_BITS-1:0] s_tdata,   // in_unit
    input  logic                 s_tlast,   // in_final
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [UNIT_BITS-1:0] m_tdata,   // out_unit
    output logic                 m_tlast,   // run_last
    output logic [1:0]           m_tuser    // unit_valid, text_end
);

    logic        push, pop, queue_full;
    job_t        push_job;
    queue_head_t head;

    jcs_front #(
        .UNIT_WIDTH(UNIT_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .queue_full(queue_full),
        .push      (push),
        .push_job  (push_job)
    );

    jcs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_job(push_job),
        .full    (queue_full),
        .pop     (pop),
        .head    (head)
    );

    jcs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule

// File: sv/jcs_front.sv
// ----------------------------------------------------------------------------
// jcs_front
// Scanner that tracks the text mode and turns each unit that gives output or ends the text into an output job.
// ----------------------------------------------------------------------------
module jcs_front
    import jcs_pkg::*;
#(
    parameter int UNIT_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [UNIT_BITS-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 queue_full,
    output logic                 push,
    output job_t                 push_job
);

    localparam int CmpWidth = (UNIT_WIDTH < UNIT_BITS) ? UNIT_WIDTH : UNIT_BITS;
    localparam logic [UNIT_BITS-1:0] UnitMask = UNIT_BITS'((64'd1 << CmpWidth) - 64'd1);

    scan_mode_t mode_reg, mode_next;
    logic [UNIT_BITS-1:0] c;
    logic fin, accept;
    logic plain_emit, emit_slash, emit_unit;
    scan_mode_t plain_mode;

    assign c = s_tdata & UnitMask;
    assign fin = s_tlast;
    assign s_tready = !queue_full;
    assign accept = s_tvalid && s_tready;

    always_comb begin
        if (c == CH_QUOTE) begin
            plain_emit = 1'b1;
            plain_mode = MODE_STR;
        end else if (c == CH_SLASH && !fin) begin
            plain_emit = 1'b0;
            plain_mode = MODE_HELD;
        end else begin
            plain_emit = 1'b1;
            plain_mode = MODE_NORMAL;
        end
    end

    always_comb begin
        emit_slash = 1'b0;
        emit_unit = 1'b0;
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_HELD: begin
                if (c == CH_SLASH) begin
                    mode_next = MODE_LINE;
                end else if (c == CH_STAR) begin
                    mode_next = MODE_BLOCK;
                end else begin
                    emit_slash = 1'b1;
                    emit_unit = plain_emit;
                    mode_next = plain_mode;
                end
            end
            MODE_STR: begin
                emit_unit = 1'b1;
                if (c == CH_BACKSLASH) begin
                    mode_next = MODE_STR_ESC;
                end else if (c == CH_QUOTE) begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_STR_ESC: begin
                emit_unit = 1'b1;
                mode_next = MODE_STR;
            end
            MODE_LINE: begin
                if (c == CH_NEWLINE) begin
                    emit_unit = plain_emit;
                    mode_next = plain_mode;
                end
            end
            MODE_BLOCK: begin
                if (c == CH_STAR) begin
                    mode_next = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR: begin
                if (c == CH_SLASH) begin
                    mode_next = MODE_NORMAL;
                end else if (c != CH_STAR) begin
                    mode_next = MODE_BLOCK;
                end
            end
            default: begin
                emit_unit = plain_emit;
                mode_next = plain_mode;
            end
        endcase
        if (fin) begin
            mode_next = MODE_NORMAL;
        end
    end

    assign push = accept && (emit_slash || emit_unit || fin);
    assign push_job = '{emit_slash: emit_slash, emit_unit: emit_unit,
                        unit: c, text_fin: fin};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

endmodule

// File: sv/jcs_queue.sv
// ----------------------------------------------------------------------------
// jcs_queue
// Short job queue between the scanner and the output stage.
// ----------------------------------------------------------------------------
module jcs_queue
    import jcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  job_t        push_job,
    output logic        full,
    input  logic        pop,
    output queue_head_t head
);

    job_t slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head.valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/jcs_back.sv
// ----------------------------------------------------------------------------
// jcs_back
// Output stage that expands each job into one or two result transfers.
// ----------------------------------------------------------------------------
module jcs_back
    import jcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  queue_head_t          head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [UNIT_BITS-1:0] m_tdata,
    output logic                 m_tlast,
    output logic [1:0]           m_tuser
);

    logic m_valid_reg;
    logic [UNIT_BITS-1:0] data_reg, data_next;
    logic last_reg, last_next;
    logic [1:0] user_reg, user_next;
    logic phase_reg, phase_next;
    logic take;

    assign take = head.valid && (!m_valid_reg || m_tready);

    always_comb begin
        phase_next = phase_reg;
        if (head.job.emit_slash && !phase_reg) begin
            data_next = CH_SLASH;
            last_next = !head.job.emit_unit;
            user_next = {head.job.text_fin && !head.job.emit_unit, 1'b1};
            pop = take && !head.job.emit_unit;
            if (take) begin
                phase_next = head.job.emit_unit;
            end
        end else begin
            data_next = head.job.emit_unit ? head.job.unit : '0;
            last_next = 1'b1;
            user_next = {head.job.text_fin, head.job.emit_unit};
            pop = take;
            if (take) begin
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= data_next;
            last_reg <= last_next;
            user_reg <= user_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = data_reg;
    assign m_tlast = last_reg;
    assign m_tuser = user_reg;

endmodule

// File: sv/jcs_checker.sv
// ----------------------------------------------------------------------------
// jcs_checker
// Port-level checks on the result stream of the comment stripper.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jcs_checker
    import jcs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [UNIT_BITS-1:0] m_tdata,
    input logic                 m_tlast,
    input logic [1:0]           m_tuser
);

    `ASSERT_SYNC(a_hold_valid, aclk, aresetn,
        (m_tvalid && !m_tready) |=> m_tvalid,
        "result dropped while stalled")
    `ASSERT_IMPLY(a_end_is_last, aclk, aresetn,
        m_tvalid && m_tuser[1], m_tlast,
        "text end without run end")
    `ASSERT_IMPLY(a_bare_mark, aclk, aresetn,
        m_tvalid && !m_tuser[0], m_tuser[1] && m_tlast && m_tdata == '0,
        "bare mark outside text end")
    `ASSERT_IMPLY(a_first_is_slash, aclk, aresetn,
        m_tvalid && !m_tlast, m_tuser[0] && m_tdata == CH_SLASH,
        "first of two results is not a slash")

endmodule

bind json_comment_stripper jcs_checker u_jcs_checker (.*);

// File: verif/jcs_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jcs_stream_checker
// Watches both stream channels of the comment stripper. It predicts the
// stripped text for every accepted input transfer and compares each result
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module jcs_stream_checker
    import jcs_pkg::*;
#(
    parameter int UNIT_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [UNIT_BITS-1:0] s_tdata,   // in_unit
    input  logic                 s_tlast,   // in_final
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [UNIT_BITS-1:0] m_tdata,   // out_unit
    input  logic                 m_tlast,   // run_last
    input  logic [1:0]           m_tuser,   // unit_valid, text_end
    output int                   fail_count,
    output int                   pending
);

    localparam logic [UNIT_BITS-1:0] UNIT_MASK = UNIT_BITS'((64'd1 << UNIT_WIDTH) - 1);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [UNIT_BITS-1:0] unit;
        logic                 unit_valid;
        logic                 run_last;
        logic                 text_end;
    } strip_result_t;

    scan_mode_t    scan_mode = MODE_NORMAL;
    strip_result_t stripped_q[$];
    strip_result_t burst[2];
    int            burst_len;
    strip_result_t got;
    strip_result_t want;

    function automatic void emit(input logic [UNIT_BITS-1:0] unit, input logic unit_valid);
        if (burst_len < 2) begin
            burst[burst_len] = '{unit: unit, unit_valid: unit_valid,
                                 run_last: 1'b0, text_end: 1'b0};
            burst_len++;
        end
    endfunction

    function automatic void take_plain(input logic [UNIT_BITS-1:0] c, input logic fin);
        if (c == CH_QUOTE) begin
            emit(c, 1'b1);
            scan_mode = MODE_STR;
        end else if (c == CH_SLASH && !fin) begin
            scan_mode = MODE_HELD;
        end else begin
            emit(c, 1'b1);
            scan_mode = MODE_NORMAL;
        end
    endfunction

    function automatic void strip_predict(input logic [UNIT_BITS-1:0] c, input logic fin);
        burst_len = 0;
        case (scan_mode)
            MODE_HELD: begin
                if (c == CH_SLASH) begin
                    scan_mode = MODE_LINE;
                end else if (c == CH_STAR) begin
                    scan_mode = MODE_BLOCK;
                end else begin
                    emit(CH_SLASH, 1'b1);
                    take_plain(c, fin);
                end
            end
            MODE_STR: begin
                emit(c, 1'b1);
                if (c == CH_BACKSLASH) scan_mode = MODE_STR_ESC;
                else if (c == CH_QUOTE) scan_mode = MODE_NORMAL;
            end
            MODE_STR_ESC: begin
                emit(c, 1'b1);
                scan_mode = MODE_STR;
            end
            MODE_LINE: begin
                if (c == CH_NEWLINE) take_plain(c, fin);
            end
            MODE_BLOCK: begin
                if (c == CH_STAR) scan_mode = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
                if (c == CH_SLASH) scan_mode = MODE_NORMAL;
                else if (c != CH_STAR) scan_mode = MODE_BLOCK;
            end
            default: begin
                take_plain(c, fin);
            end
        endcase
        if (fin) begin
            if (burst_len == 0) emit('0, 1'b0);
            burst[burst_len-1].text_end = 1'b1;
            scan_mode = MODE_NORMAL;
        end
        if (burst_len > 0) burst[burst_len-1].run_last = 1'b1;
        for (int k = 0; k < burst_len; k++) stripped_q.push_back(burst[k]);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode = MODE_NORMAL;
            stripped_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                strip_predict(s_tdata & UNIT_MASK, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                got = '{unit: m_tdata, unit_valid: m_tuser[0],
                        run_last: m_tlast, text_end: m_tuser[1]};
                if (stripped_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("Unexpected result transfer: unit %h valid %b last %b end %b",
                                 got.unit, got.unit_valid, got.run_last, got.text_end);
                    end
                end else begin
                    want = stripped_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("Mismatch: unit %h/%h valid %b/%b last %b/%b end %b/%b %s",
                                     want.unit, got.unit, want.unit_valid, got.unit_valid,
                                     want.run_last, got.run_last, want.text_end, got.text_end,
                                     "(expected/actual)");
                        end
                    end
                end
            end
            pending = stripped_q.size();
        end
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives text through the comment stripper: a directed set of short texts
// for the corner cases, then random texts built from strings, comments,
// lone slashes and noise, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    import jcs_pkg::*;

    localparam int ITEM_TOTAL   = 1300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [UNIT_BITS-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [UNIT_BITS-1:0] m_tdata;
    logic                 m_tlast;
    logic [1:0]           m_tuser;

    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_asks = 0;
    int                   hold_served = 0;
    int                   hold_left = 0;
    int                   cycle_count = 0;
    int                   units_sent = 0;
    int                   fail_count;
    int                   pending;
    logic [UNIT_BITS-1:0] text_units[$];

    always #6 aclk = ~aclk;

    json_comment_stripper i_dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
    );

    jcs_stream_checker i_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
        .fail_count, .pending
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // A requested hold-off keeps the result side stalled long enough for the
    // block to fill up and stop taking input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_served) begin
            m_tready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    function automatic logic [UNIT_BITS-1:0] rand_char();
        case ($urandom_range(0, 9))
            0: return CH_SLASH;
            1: return CH_STAR;
            2: return CH_QUOTE;
            3: return CH_BACKSLASH;
            4: return CH_NEWLINE;
            5: return UNIT_BITS'($urandom_range(0, 65535));
            default: return UNIT_BITS'($urandom_range(32'h20, 32'h7e));
        endcase
    endfunction

    task automatic send_unit(input logic [UNIT_BITS-1:0] unit, input logic fin);
        if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= unit;
        s_tlast <= fin;
        do @(posedge aclk); while (!s_tready);
        units_sent++;
    endtask

    task automatic build_text();
        int tokens;
        int cut;
        text_units.delete();
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 4))
                        text_units.push_back(UNIT_BITS'($urandom_range(32'h20, 32'h7e)));
                end
                2, 3: begin
                    text_units.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(0, 3) == 0) text_units.push_back(CH_BACKSLASH);
                        text_units.push_back(rand_char());
                    end
                    text_units.push_back(CH_QUOTE);
                end
                4: begin
                    text_units.push_back(CH_SLASH);
                    text_units.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 5)) text_units.push_back(rand_char());
                    text_units.push_back(CH_NEWLINE);
                end
                5, 6: begin
                    text_units.push_back(CH_SLASH);
                    text_units.push_back(CH_STAR);
                    repeat ($urandom_range(0, 6)) text_units.push_back(rand_char());
                    repeat ($urandom_range(1, 3)) text_units.push_back(CH_STAR);
                    text_units.push_back(CH_SLASH);
                end
                7: begin
                    text_units.push_back(CH_SLASH);
                    text_units.push_back(rand_char());
                end
                8: begin
                    text_units.push_back(UNIT_BITS'($urandom_range(0, 65535)));
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        text_units.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
                end
            endcase
        end
        // Some texts stop in the middle of a string or comment.
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, text_units.size());
            while (text_units.size() > cut) void'(text_units.pop_back());
        end
    endtask

    task automatic send_text();
        foreach (text_units[i]) send_unit(text_units[i], i == text_units.size() - 1);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_unit(16'h0000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        send_unit(CH_SLASH, 1'b1);
        send_unit(CH_SLASH, 1'b0);
        send_unit(CH_QUOTE, 1'b0);
        send_unit(CH_BACKSLASH, 1'b0);
        send_unit(CH_QUOTE, 1'b0);
        send_unit(CH_BACKSLASH, 1'b1);
        send_unit(CH_SLASH, 1'b0);
        send_unit(CH_STAR, 1'b1);
        send_unit(CH_SLASH, 1'b0);
        send_unit(CH_STAR, 1'b0);
        send_unit(CH_SLASH, 1'b0);
        send_unit(16'h0078, 1'b1);
        send_unit(CH_SLASH, 1'b0);
        send_unit(CH_SLASH, 1'b0);
        send_unit(16'h007A, 1'b0);
        send_unit(CH_NEWLINE, 1'b0);
        send_unit(CH_SLASH, 1'b0);
        send_unit(CH_STAR, 1'b0);
        send_unit(CH_STAR, 1'b0);
        send_unit(CH_STAR, 1'b0);
        send_unit(CH_SLASH, 1'b0);
        send_unit(16'h006B, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 51;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 51;
                end
                default: begin
                    send_idle_pct = 34;
                    recv_stall_pct = 34;
                end
            endcase
            while (units_sent < (phase + 1) * ITEM_TOTAL / 4) begin
                if (phase == 0 && hold_asks == 0 && units_sent >= 120) hold_asks++;
                build_text();
                send_text();
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/jcs_pkg.sv
sv/jcs_front.sv
sv/jcs_queue.sv
sv/jcs_back.sv
sv/json_comment_stripper.sv
sv/jcs_checker.sv
verif/jcs_stream_checker.sv
verif/testbench.sv
